// File: rtl/phy_medium_state_tracker_core_defines.svh
// Assertion macros used by the checker file of the medium state tracker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PHY_MEDIUM_STATE_TRACKER_CORE_DEFINES_SVH
`define PHY_MEDIUM_STATE_TRACKER_CORE_DEFINES_SVH

// Concurrent check, ignored while reset is held.
`define PMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check that also holds through reset.
`define PMST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pmst_pkg.sv
// Shared types and constants of the medium state tracker.
// Used by the front, queue, back, top level and checker; depends on nothing.
package pmst_pkg;

  typedef enum logic [2:0] {
    CMD_TX     = 3'd0,
    CMD_RX     = 3'd1,
    CMD_SW     = 3'd2,
    CMD_RX_OK  = 3'd3,
    CMD_RX_ERR = 3'd4,
    CMD_CCA    = 3'd5,
    CMD_QUERY  = 3'd6
  } pmst_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_CCA  = 3'd1,
    ST_TX   = 3'd2,
    ST_RX   = 3'd3,
    ST_SW   = 3'd4
  } pmst_state_t;

  typedef enum logic [1:0] {
    RXO_NONE = 2'd0,
    RXO_OK   = 2'd1,
    RXO_ERR  = 2'd2
  } pmst_rxo_t;

  typedef enum logic [3:0] {
    B_EVAL = 4'b0001,
    B_CUR  = 4'b0010,
    B_REC  = 4'b0100,
    B_STAT = 4'b1000
  } pmst_bst_t;

  // Decoded command; all flags low means a status query.
  typedef struct packed {
    logic tx;
    logic rx;
    logic sw;
    logic rx_end;
    logic rx_fail;
    logic cca;
  } pmst_cls_t;

  localparam int CLS_W = $bits(pmst_cls_t);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Record slots, emitted in this order.
  localparam int REC_HIST  = 0;
  localparam int REC_IDLE  = 1;
  localparam int REC_CCA   = 2;
  localparam int REC_RX    = 3;
  localparam int REC_NEW   = 4;
  localparam int REC_SLOTS = 5;

  typedef logic [REC_SLOTS-1:0] pmst_recmask_t;

endpackage

// File: rtl/pmst_front.sv
// Front end of the medium state tracker: input handshake, command decode and
// saturated end time. Depends on pmst_pkg.
module pmst_front #(
  parameter int TIME_BITS = 48,
  parameter int DUR_BITS  = 32
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_cmd,
  input  logic [TIME_BITS-1:0]  in_now,
  input  logic [DUR_BITS-1:0]   in_dur,
  input  logic                  q_full,
  output logic                  q_push,
  output pmst_pkg::pmst_cls_t   q_cls,
  output logic [TIME_BITS-1:0]  q_fin
);
  import pmst_pkg::*;

  localparam int SUM_W = ((TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS) + 1;

  logic [SUM_W-1:0] sum;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Clamp now + duration to the top of the time range.
  assign sum   = SUM_W'(in_now) + SUM_W'(in_dur);
  assign q_fin = (|sum[SUM_W-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];

  always_comb begin
    q_cls = '0;
    unique case (in_cmd) inside
      CMD_TX:    q_cls.tx  = 1'b1;
      CMD_RX:    q_cls.rx  = 1'b1;
      CMD_SW:    q_cls.sw  = 1'b1;
      CMD_RX_OK, CMD_RX_ERR: begin
        q_cls.rx_end  = 1'b1;
        q_cls.rx_fail = (in_cmd == CMD_RX_ERR);
      end
      CMD_CCA:   q_cls.cca = 1'b1;
      CMD_QUERY: q_cls     = '0;
      default:   q_cls     = '0;
    endcase
  end

endmodule

// File: rtl/pmst_queue.sv
// Short queue between the front and back ends of the medium state tracker.
// Depends on pmst_pkg for its depth.
module pmst_queue #(
  parameter int DW = 102
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] pop_data
);
  import pmst_pkg::*;

  logic [DW-1:0]     mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/pmst_back.sv
// Back end of the medium state tracker: medium state, event sequencer and
// output register. Depends on pmst_pkg.
module pmst_back #(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  pmst_pkg::pmst_cls_t   q_cls,
  input  logic [TIME_BITS-1:0]  q_now,
  input  logic [TIME_BITS-1:0]  q_fin,
  output logic                  q_pop,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_status,
  output logic [2:0]            out_rec_state,
  output logic [TIME_BITS-1:0]  out_rec_start,
  output logic [TIME_BITS-1:0]  out_rec_length,
  output logic [2:0]            out_cur_state,
  output logic [TIME_BITS-1:0]  out_delay,
  output logic [TIME_BITS-1:0]  out_age,
  output logic [TIME_BITS-1:0]  out_last_rx_begin,
  output logic                  out_error,
  output logic [1:0]            out_rx_outcome
);
  import pmst_pkg::*;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  function automatic tstamp_t f_max(tstamp_t a, tstamp_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic tstamp_t f_sat_sub(tstamp_t a, tstamp_t b);
    return (a > b) ? a - b : '0;
  endfunction

  // Medium state
  logic    rx_active_r, rx_active_nxt;
  tstamp_t tx_end_r, tx_end_nxt;
  tstamp_t rx_end_r, rx_end_nxt;
  tstamp_t cca_end_r, cca_end_nxt;
  tstamp_t sw_end_r, sw_end_nxt;
  tstamp_t rx_begin_r, rx_begin_nxt;
  tstamp_t cca_begin_r, cca_begin_nxt;
  tstamp_t last_change_r, last_change_nxt;

  // Sequencer and per-item work registers
  pmst_bst_t     bst_r, bst_nxt;
  pmst_recmask_t mask_r, mask_nxt;
  tstamp_t       t_r, t_nxt;
  tstamp_t       fin_r, fin_nxt;
  tstamp_t       bs_r, bs_nxt;
  tstamp_t       idf_r, idf_nxt;
  pmst_state_t   new_st_r, new_st_nxt;
  logic          err_r, err_nxt;
  pmst_rxo_t     rxo_r, rxo_nxt;
  pmst_state_t   cur_r, cur_nxt;
  tstamp_t       sel_end_r, sel_end_nxt;
  tstamp_t       age_r, age_nxt;

  // Output register
  logic          o_valid_r;
  logic          o_status_r;
  logic [2:0]    o_rst_r;
  tstamp_t       o_rstart_r, o_rlen_r;
  logic [2:0]    o_cur_r;
  tstamp_t       o_delay_r, o_age_r, o_lrb_r;
  logic          o_err_r;
  logic [1:0]    o_rxo_r;

  // Evaluation of the item at the queue head
  pmst_state_t   st_ev;
  logic          err_ev, close_ev, idle_close_ev, ccadom_ev;
  tstamp_t       bs_ev, idf_ev;
  pmst_recmask_t mask_ev;

  // Status and record selection
  pmst_state_t   st_cur;
  tstamp_t       sel_cur;
  pmst_recmask_t rec_hit, mask_rest;
  pmst_state_t   rec_st;
  tstamp_t       rec_a, rec_b;

  logic o_free, load_rec, load_stat;

  assign o_free = !o_valid_r || out_ready;

  always_comb begin
    if (tx_end_r > q_now) begin
      st_ev = ST_TX;
    end else if (rx_active_r) begin
      st_ev = ST_RX;
    end else if (sw_end_r > q_now) begin
      st_ev = ST_SW;
    end else if (cca_end_r > q_now) begin
      st_ev = ST_CCA;
    end else begin
      st_ev = ST_IDLE;
    end
  end

  assign err_ev = ((q_cls.tx || q_cls.sw) && (st_ev == ST_TX || st_ev == ST_SW))
               || (q_cls.rx && !(st_ev == ST_IDLE || st_ev == ST_CCA))
               || (q_cls.rx_end && st_ev != ST_RX);

  assign close_ev      = (q_cls.tx || q_cls.sw || q_cls.rx) && !err_ev;
  assign idle_close_ev = (close_ev || q_cls.cca) && st_ev == ST_IDLE;
  assign bs_ev         = f_max(f_max(tx_end_r, rx_end_r), f_max(cca_begin_r, sw_end_r));
  assign idf_ev        = f_max(f_max(cca_end_r, rx_end_r), f_max(tx_end_r, sw_end_r));
  assign ccadom_ev     = (cca_end_r > rx_end_r) && (cca_end_r > sw_end_r)
                      && (cca_end_r > tx_end_r);

  always_comb begin
    mask_ev           = '0;
    mask_ev[REC_HIST] = idle_close_ev && ccadom_ev;
    mask_ev[REC_IDLE] = idle_close_ev;
    mask_ev[REC_CCA]  = close_ev && st_ev == ST_CCA;
    mask_ev[REC_RX]   = (close_ev && st_ev == ST_RX) || (q_cls.rx_end && !err_ev);
    mask_ev[REC_NEW]  = (q_cls.tx || q_cls.sw) && !err_ev;
  end

  // State after the update, seen from the item's time stamp
  always_comb begin
    if (tx_end_r > t_r) begin
      st_cur  = ST_TX;
      sel_cur = tx_end_r;
    end else if (rx_active_r) begin
      st_cur  = ST_RX;
      sel_cur = rx_end_r;
    end else if (sw_end_r > t_r) begin
      st_cur  = ST_SW;
      sel_cur = sw_end_r;
    end else if (cca_end_r > t_r) begin
      st_cur  = ST_CCA;
      sel_cur = cca_end_r;
    end else begin
      st_cur  = ST_IDLE;
      sel_cur = '0;
    end
  end

  // Take the lowest pending record slot
  always_comb begin
    rec_hit = '0;
    rec_st  = ST_IDLE;
    rec_a   = t_r;
    rec_b   = t_r;
    if (mask_r[REC_HIST]) begin
      rec_hit[REC_HIST] = 1'b1;
      rec_st = ST_CCA;
      rec_a  = bs_r;
      rec_b  = idf_r;
    end else if (mask_r[REC_IDLE]) begin
      rec_hit[REC_IDLE] = 1'b1;
      rec_st = ST_IDLE;
      rec_a  = idf_r;
    end else if (mask_r[REC_CCA]) begin
      rec_hit[REC_CCA] = 1'b1;
      rec_st = ST_CCA;
      rec_a  = bs_r;
    end else if (mask_r[REC_RX]) begin
      rec_hit[REC_RX] = 1'b1;
      rec_st = ST_RX;
      rec_a  = rx_begin_r;
    end else if (mask_r[REC_NEW]) begin
      rec_hit[REC_NEW] = 1'b1;
      rec_st = new_st_r;
      rec_b  = fin_r;
    end
  end

  assign mask_rest = mask_r & ~rec_hit;

  always_comb begin
    bst_nxt         = bst_r;
    mask_nxt        = mask_r;
    q_pop           = 1'b0;
    load_rec        = 1'b0;
    load_stat       = 1'b0;
    t_nxt           = t_r;
    fin_nxt         = fin_r;
    bs_nxt          = bs_r;
    idf_nxt         = idf_r;
    new_st_nxt      = new_st_r;
    err_nxt         = err_r;
    rxo_nxt         = rxo_r;
    cur_nxt         = cur_r;
    sel_end_nxt     = sel_end_r;
    age_nxt         = age_r;
    rx_active_nxt   = rx_active_r;
    tx_end_nxt      = tx_end_r;
    rx_end_nxt      = rx_end_r;
    cca_end_nxt     = cca_end_r;
    sw_end_nxt      = sw_end_r;
    rx_begin_nxt    = rx_begin_r;
    cca_begin_nxt   = cca_begin_r;
    last_change_nxt = last_change_r;

    unique case (bst_r)
      B_EVAL: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          t_nxt      = q_now;
          fin_nxt    = q_fin;
          bs_nxt     = bs_ev;
          idf_nxt    = idf_ev;
          mask_nxt   = mask_ev;
          new_st_nxt = q_cls.tx ? ST_TX : ST_SW;
          err_nxt    = err_ev;
          rxo_nxt    = RXO_NONE;
          if (q_cls.rx_end && !err_ev) begin
            rxo_nxt = q_cls.rx_fail ? RXO_ERR : RXO_OK;
          end
          // Apply the event; an illegal one changes nothing
          if (!err_ev) begin
            if (q_cls.tx || q_cls.sw || q_cls.rx || q_cls.rx_end) begin
              last_change_nxt = q_now;
            end
            if ((q_cls.tx || q_cls.sw) && st_ev == ST_RX) begin
              rx_active_nxt = 1'b0;
              rx_end_nxt    = q_now;
            end
            if (q_cls.tx) begin
              tx_end_nxt = q_fin;
            end
            if (q_cls.sw) begin
              sw_end_nxt = q_fin;
              if (q_now < cca_end_r) begin
                cca_end_nxt = q_now;
              end
            end
            if (q_cls.rx) begin
              rx_active_nxt = 1'b1;
              rx_begin_nxt  = q_now;
              rx_end_nxt    = q_fin;
            end
            if (q_cls.rx_end) begin
              rx_active_nxt = 1'b0;
              rx_end_nxt    = q_now;
            end
            if (q_cls.cca) begin
              if (st_ev != ST_CCA) begin
                cca_begin_nxt = q_now;
              end
              cca_end_nxt = f_max(cca_end_r, q_fin);
            end
          end
          bst_nxt = B_CUR;
        end
      end
      B_CUR: begin
        cur_nxt     = st_cur;
        sel_end_nxt = sel_cur;
        age_nxt     = f_sat_sub(t_r, last_change_r);
        bst_nxt     = (mask_r != '0) ? B_REC : B_STAT;
      end
      B_REC: begin
        if (o_free) begin
          load_rec = 1'b1;
          mask_nxt = mask_rest;
          if (mask_rest == '0) begin
            bst_nxt = B_STAT;
          end
        end
      end
      B_STAT: begin
        if (o_free) begin
          load_stat = 1'b1;
          bst_nxt   = B_EVAL;
        end
      end
      default: bst_nxt = B_EVAL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r         <= B_EVAL;
      mask_r        <= '0;
      o_valid_r     <= 1'b0;
      rx_active_r   <= 1'b0;
      tx_end_r      <= '0;
      rx_end_r      <= '0;
      cca_end_r     <= '0;
      sw_end_r      <= '0;
      rx_begin_r    <= '0;
      cca_begin_r   <= '0;
      last_change_r <= '0;
    end else begin
      bst_r         <= bst_nxt;
      mask_r        <= mask_nxt;
      rx_active_r   <= rx_active_nxt;
      tx_end_r      <= tx_end_nxt;
      rx_end_r      <= rx_end_nxt;
      cca_end_r     <= cca_end_nxt;
      sw_end_r      <= sw_end_nxt;
      rx_begin_r    <= rx_begin_nxt;
      cca_begin_r   <= cca_begin_nxt;
      last_change_r <= last_change_nxt;
      if (load_rec || load_stat) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    fin_r     <= fin_nxt;
    bs_r      <= bs_nxt;
    idf_r     <= idf_nxt;
    new_st_r  <= new_st_nxt;
    err_r     <= err_nxt;
    rxo_r     <= rxo_nxt;
    cur_r     <= cur_nxt;
    sel_end_r <= sel_end_nxt;
    age_r     <= age_nxt;
    if (load_rec) begin
      o_status_r <= 1'b0;
      o_rst_r    <= rec_st;
      o_rstart_r <= rec_a;
      o_rlen_r   <= f_sat_sub(rec_b, rec_a);
      o_cur_r    <= ST_IDLE;
      o_delay_r  <= '0;
      o_age_r    <= '0;
      o_lrb_r    <= '0;
      o_err_r    <= 1'b0;
      o_rxo_r    <= RXO_NONE;
    end else if (load_stat) begin
      o_status_r <= 1'b1;
      o_rst_r    <= ST_IDLE;
      o_rstart_r <= '0;
      o_rlen_r   <= '0;
      o_cur_r    <= cur_r;
      o_delay_r  <= f_sat_sub(sel_end_r, t_r);
      o_age_r    <= age_r;
      o_lrb_r    <= rx_begin_r;
      o_err_r    <= err_r;
      o_rxo_r    <= rxo_r;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_status        = o_status_r;
  assign out_rec_state     = o_rst_r;
  assign out_rec_start     = o_rstart_r;
  assign out_rec_length    = o_rlen_r;
  assign out_cur_state     = o_cur_r;
  assign out_delay         = o_delay_r;
  assign out_age           = o_age_r;
  assign out_last_rx_begin = o_lrb_r;
  assign out_error         = o_err_r;
  assign out_rx_outcome    = o_rxo_r;

endmodule

// File: rtl/phy_medium_state_tracker_core.sv
// Radio medium state tracker. Each input transfer is one event (command, time
// stamp, duration); the block answers with zero to three interval records
// (start, length, state of intervals that closed or were opened with a known
// length) followed by one status item (current state, delay to idle, time in
// state, last reception start, error flag, reception outcome).
// Input channel in_*: decoded and written into a two-entry queue; in_tready
// drops only while that queue is full.
// Output channel out_*: out_tuser is 0 on a record and 1 on the status item,
// out_tlast marks the status item, which always closes an event's results.
// Sequencing: the back end takes each event through evaluation, state capture,
// one step per record and a status step, and takes the next event only after
// loading that status item; the sequencer emits one result per cycle through a
// single output register while out_tready stays high.
// Stalls: while out_tready is low the output register holds its item, the
// sequencer waits and the queue keeps taking events until it is full.
// Reset (rst_n low, synchronous) clears all end and start times, the
// reception flag, the queue and the output valid.
// Depends on pmst_pkg, pmst_front, pmst_queue and pmst_back.
module phy_medium_state_tracker_core #(
  parameter int TIME_BITS = 48,
  parameter int DUR_BITS  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // cmd, now, duration (lowest bits first)
  input  logic [((3 + TIME_BITS + DUR_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // rec_state, rec_start, rec_length, cur_state, delay_to_idle, state_age,
  // last_rx_begin, error, rx_outcome (lowest bits first)
  output logic [((9 + 5 * TIME_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // kind
  output logic                                    out_tuser,
  output logic                                    out_tlast
);
  import pmst_pkg::*;

  localparam int OUT_W = ((9 + 5 * TIME_BITS + 7) / 8) * 8;
  localparam int DW    = CLS_W + 2 * TIME_BITS;

  logic [2:0]           in_cmd;
  logic [TIME_BITS-1:0] in_now;
  logic [DUR_BITS-1:0]  in_dur;

  pmst_cls_t            f_cls, b_cls;
  logic [TIME_BITS-1:0] f_fin, b_now, b_fin;
  logic                 q_push, q_full, q_pop, q_valid;
  logic [DW-1:0]        q_wdata, q_rdata;

  logic                 b_status, b_error;
  logic [2:0]           b_rec_state, b_cur_state;
  logic [1:0]           b_rx_outcome;
  logic [TIME_BITS-1:0] b_rec_start, b_rec_length, b_delay, b_age, b_lrb;

  assign in_cmd = in_tdata[2:0];
  assign in_now = in_tdata[3 +: TIME_BITS];
  assign in_dur = in_tdata[3 + TIME_BITS +: DUR_BITS];

  pmst_front #(
    .TIME_BITS (TIME_BITS),
    .DUR_BITS  (DUR_BITS)
  ) u_front (
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_cmd),
    .in_now   (in_now),
    .in_dur   (in_dur),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cls    (f_cls),
    .q_fin    (f_fin)
  );

  assign q_wdata = {f_cls, in_now, f_fin};

  pmst_queue #(
    .DW (DW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  assign b_cls = q_rdata[DW-1 -: CLS_W];
  assign b_now = q_rdata[TIME_BITS +: TIME_BITS];
  assign b_fin = q_rdata[TIME_BITS-1:0];

  pmst_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_cls             (b_cls),
    .q_now             (b_now),
    .q_fin             (b_fin),
    .q_pop             (q_pop),
    .out_ready         (out_tready),
    .out_valid         (out_tvalid),
    .out_status        (b_status),
    .out_rec_state     (b_rec_state),
    .out_rec_start     (b_rec_start),
    .out_rec_length    (b_rec_length),
    .out_cur_state     (b_cur_state),
    .out_delay         (b_delay),
    .out_age           (b_age),
    .out_last_rx_begin (b_lrb),
    .out_error         (b_error),
    .out_rx_outcome    (b_rx_outcome)
  );

  assign out_tdata = OUT_W'({b_rx_outcome, b_error, b_lrb, b_age, b_delay, b_cur_state,
                             b_rec_length, b_rec_start, b_rec_state});
  assign out_tuser = b_status;
  assign out_tlast = b_status;

endmodule

// File: rtl/pmst_checker.sv
// Port-level checks of the medium state tracker's result channel, bound to
// the top level. Depends on pmst_pkg and the shared assertion macros.
`include "phy_medium_state_tracker_core_defines.svh"

module pmst_checker #(
  parameter int TIME_BITS = 48
) (
  input logic                                           clk,
  input logic                                           rst_n,
  input logic                                           out_tvalid,
  input logic                                           out_tready,
  input logic [((9 + 5 * TIME_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  input logic                                           out_tuser,
  input logic                                           out_tlast,
  input logic                                           in_tready
);
  import pmst_pkg::*;

  localparam int OFF_CUR = 3 + 2 * TIME_BITS;
  localparam int OFF_DLY = OFF_CUR + 3;
  localparam int OFF_ERR = OFF_DLY + 3 * TIME_BITS;
  localparam int OFF_RXO = OFF_ERR + 1;

  logic rec_item, idle_stat;

  assign rec_item  = out_tvalid && !out_tuser;
  assign idle_stat = out_tvalid && out_tuser && out_tdata[OFF_CUR +: 3] == ST_IDLE;

  `PMST_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `PMST_ASSERT(a_last_stat, out_tvalid |-> out_tlast == out_tuser, "tlast not on status item")
  `PMST_ASSERT(a_idle_dly, idle_stat |-> out_tdata[OFF_DLY +: TIME_BITS] == '0, "idle with delay")
  `PMST_ASSERT(a_rec_clean, rec_item |-> !out_tdata[OFF_ERR] && out_tdata[OFF_RXO +: 2] == RXO_NONE, "record with status")
  `PMST_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid && in_tready, "busy after reset")

endmodule

bind phy_medium_state_tracker_core pmst_checker #(
  .TIME_BITS (TIME_BITS)
) u_pmst_checker (.*);

// File: tb/phy_medium_state_tracker_core_tb.sv
// Self-checking bench for the radio medium state tracker: drives event transfers,
// predicts interval records and status items, and checks every result transfer.
// Depends on pmst_pkg and phy_medium_state_tracker_core.
`timescale 1ns / 100ps

module phy_medium_state_tracker_core_tb;
  import pmst_pkg::*;

  localparam logic [2:0]  CMD_SPARE   = 3'd7;   // unused code, handled as a query
  localparam logic [47:0] TIME_TOP    = '1;
  localparam int          CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        kind;
    pmst_state_t rec_state;
    logic [47:0] rec_start;
    logic [47:0] rec_length;
    pmst_state_t cur_state;
    logic [47:0] delay_to_idle;
    logic [47:0] state_age;
    logic [47:0] last_rx_begin;
    logic        error;
    pmst_rxo_t   rx_outcome;
    logic        last;
  } report_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [47:0] at;
    logic [31:0] dur;
    bit          drain;
  } phy_event_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [87:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [255:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  phy_medium_state_tracker_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Tracker copy: end times, start times and the reception flag
  logic        rx_on = 1'b0;
  logic [47:0] tx_until = '0, rx_until = '0, cca_until = '0, sw_until = '0;
  logic [47:0] rx_from = '0, cca_from = '0, state_since = '0;

  phy_event_t events_to_send[$];
  report_t    reports_due[$];
  int         records_in_event;
  int         events_taken = 0;
  int         records_total = 0;
  int         illegal_total = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         cycles = 0;
  int         squeeze_left = 0;
  bit         squeezed = 1'b0;
  logic       calm;

  assign calm = (events_taken >= 150) && (events_taken < 230);

  function automatic logic [47:0] later(input logic [47:0] a, input logic [47:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [47:0] span(input logic [47:0] a, input logic [47:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Saturate the end time at the top of the time range
  function automatic logic [47:0] end_of(input logic [47:0] t, input logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, t} + {17'b0, d};
    return s[48] ? TIME_TOP : s[47:0];
  endfunction

  function automatic pmst_state_t state_at_time(input logic [47:0] t);
    if (tx_until > t) return ST_TX;
    if (rx_on) return ST_RX;
    if (sw_until > t) return ST_SW;
    if (cca_until > t) return ST_CCA;
    return ST_IDLE;
  endfunction

  task automatic add_record(input pmst_state_t st, input logic [47:0] from,
                            input logic [47:0] len);
    report_t r;
    if (records_in_event < 3) begin
      r = '0;
      r.rec_state = st;
      r.rec_start = from;
      r.rec_length = len;
      reports_due = {reports_due, r};
      records_in_event++;
      records_total++;
    end
  endtask

  // Busy period start: the latest of the tx, rx and switching end times and the cca start
  function automatic logic [47:0] busy_begin();
    return later(later(tx_until, rx_until), later(cca_from, sw_until));
  endfunction

  task automatic close_idle(input logic [47:0] t);
    logic [47:0] idle_from;
    idle_from = later(later(cca_until, rx_until), later(tx_until, sw_until));
    if (cca_until > rx_until && cca_until > sw_until && cca_until > tx_until)
      add_record(ST_CCA, busy_begin(), span(idle_from, busy_begin()));
    add_record(ST_IDLE, idle_from, span(t, idle_from));
  endtask

  task automatic close_current(input pmst_state_t st, input logic [47:0] t);
    case (st)
      ST_RX: begin
        rx_on = 1'b0;
        add_record(ST_RX, rx_from, span(t, rx_from));
        rx_until = t;
      end
      ST_CCA: add_record(ST_CCA, busy_begin(), span(t, busy_begin()));
      ST_IDLE: close_idle(t);
      default: ;
    endcase
  endtask

  // Update the tracker copy for one event and queue its records and status item
  task automatic track_event(input logic [2:0] cmd, input logic [47:0] t,
                             input logic [31:0] d);
    pmst_state_t st;
    logic        err;
    pmst_rxo_t   rxo;
    logic [47:0] end_t;
    report_t     r;
    st = state_at_time(t);
    err = 1'b0;
    rxo = RXO_NONE;
    records_in_event = 0;
    case (cmd)
      CMD_TX: begin
        if (st == ST_TX || st == ST_SW) err = 1'b1;
        else begin
          close_current(st, t);
          end_t = end_of(t, d);
          add_record(ST_TX, t, end_t - t);
          state_since = t;
          tx_until = end_t;
        end
      end
      CMD_RX: begin
        if (st != ST_IDLE && st != ST_CCA) err = 1'b1;
        else begin
          close_current(st, t);
          state_since = t;
          rx_on = 1'b1;
          rx_from = t;
          rx_until = end_of(t, d);
        end
      end
      CMD_SW: begin
        if (st == ST_TX || st == ST_SW) err = 1'b1;
        else begin
          close_current(st, t);
          // cut a pending cca busy period back to now
          if (t < cca_until) cca_until = t;
          end_t = end_of(t, d);
          add_record(ST_SW, t, end_t - t);
          state_since = t;
          sw_until = end_t;
        end
      end
      CMD_RX_OK, CMD_RX_ERR: begin
        if (st != ST_RX) err = 1'b1;
        else begin
          add_record(ST_RX, rx_from, span(t, rx_from));
          state_since = t;
          rx_on = 1'b0;
          rx_until = t;
          rxo = (cmd == CMD_RX_OK) ? RXO_OK : RXO_ERR;
        end
      end
      CMD_CCA: begin
        if (st == ST_IDLE) close_idle(t);
        if (state_at_time(t) != ST_CCA) cca_from = t;
        cca_until = later(cca_until, end_of(t, d));
      end
      default: ;
    endcase
    r = '0;
    r.kind = 1'b1;
    r.cur_state = state_at_time(t);
    case (r.cur_state)
      ST_TX:   r.delay_to_idle = span(tx_until, t);
      ST_RX:   r.delay_to_idle = span(rx_until, t);
      ST_SW:   r.delay_to_idle = span(sw_until, t);
      ST_CCA:  r.delay_to_idle = span(cca_until, t);
      default: r.delay_to_idle = '0;
    endcase
    r.state_age = span(t, state_since);
    r.last_rx_begin = rx_from;
    r.error = err;
    r.rx_outcome = rxo;
    r.last = 1'b1;
    reports_due = {reports_due, r};
    if (err) illegal_total++;
  endtask

  task automatic add_event(input logic [2:0] cmd, input logic [47:0] at,
                           input logic [31:0] dur, input bit drain = 1'b0);
    phy_event_t e;
    e.cmd = cmd;
    e.at = at;
    e.dur = dur;
    e.drain = drain;
    events_to_send = {events_to_send, e};
  endtask

  // Event sender: predict on each input transfer, then present the next event
  always @(posedge clk) begin : send_events
    phy_event_t e;
    bit         go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_event(in_tdata[2:0], in_tdata[50:3], in_tdata[82:51]);
        events_taken++;
      end
      if (!in_tvalid || in_tready) begin
        go = (events_to_send.size() != 0) && (calm || $urandom_range(99) >= 8);
        // hold a draining event back until every result has arrived
        if (go && events_to_send[0].drain && reports_due.size() != 0) go = 1'b0;
        if (go) begin
          e = events_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, e.dur, e.at, e.cmd};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off
  always @(posedge clk) begin : take_results
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (squeeze_left != 0) begin
      squeeze_left--;
      out_tready <= 1'b0;
    end else if (!squeezed && events_taken >= 60) begin
      squeezed = 1'b1;
      squeeze_left = 250;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin : check_results
    report_t seen;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind = out_tuser;
      seen.rec_state = pmst_state_t'(out_tdata[2:0]);
      seen.rec_start = out_tdata[50:3];
      seen.rec_length = out_tdata[98:51];
      seen.cur_state = pmst_state_t'(out_tdata[101:99]);
      seen.delay_to_idle = out_tdata[149:102];
      seen.state_age = out_tdata[197:150];
      seen.last_rx_begin = out_tdata[245:198];
      seen.error = out_tdata[246];
      seen.rx_outcome = pmst_rxo_t'(out_tdata[248:247]);
      seen.last = out_tlast;
      results_seen++;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: kind %0d state %0d last %0d",
                   $realtime, seen.kind, seen.rec_state, seen.last);
      end else begin
        want = reports_due.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: exp k%0d r%0d/%0d/%0d c%0d d%0d a%0d b%0d e%0d o%0d l%0d",
                     $realtime, want.kind, want.rec_state, want.rec_start,
                     want.rec_length, want.cur_state, want.delay_to_idle,
                     want.state_age, want.last_rx_begin, want.error,
                     want.rx_outcome, want.last);
            $display("%0t: got k%0d r%0d/%0d/%0d c%0d d%0d a%0d b%0d e%0d o%0d l%0d",
                     $realtime, seen.kind, seen.rec_state, seen.rec_start,
                     seen.rec_length, seen.cur_state, seen.delay_to_idle,
                     seen.state_age, seen.last_rx_begin, seen.error,
                     seen.rx_outcome, seen.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL phy_medium_state_tracker_core");
      $finish;
    end
  end

  initial begin : stimulus
    logic [47:0] tick;
    logic [2:0]  cmd;
    logic [31:0] dur;
    int          r;

    // Opening sequence: every command, illegal transitions, zero and full durations
    add_event(CMD_QUERY, 48'd0, 32'd0);
    add_event(CMD_RX_OK, 48'd5, 32'd0);
    add_event(CMD_CCA, 48'd10, 32'd20);
    add_event(CMD_QUERY, 48'd15, 32'd0);
    add_event(CMD_RX, 48'd20, 32'd100);
    add_event(CMD_RX, 48'd25, 32'd7);
    add_event(CMD_TX, 48'd30, 32'd10);
    add_event(CMD_SW, 48'd35, 32'd5);
    add_event(CMD_TX, 48'd36, 32'd5);
    add_event(CMD_QUERY, 48'd50, 32'd0);
    add_event(CMD_CCA, 48'd55, 32'd30);
    add_event(CMD_CCA, 48'd60, 32'd5);
    add_event(CMD_SW, 48'd70, 32'd20);
    add_event(CMD_RX, 48'd75, 32'd5);
    add_event(CMD_RX_ERR, 48'd80, 32'd0);
    add_event(CMD_RX, 48'd100, 32'd50, 1'b1);
    add_event(CMD_RX_ERR, 48'd120, 32'd0);
    add_event(CMD_RX, 48'd130, 32'd0);
    add_event(CMD_QUERY, 48'd140, 32'd0);
    add_event(CMD_RX_OK, 48'd150, 32'd0);
    add_event(CMD_TX, 48'd160, 32'd0);
    add_event(CMD_CCA, 48'd100, 32'd10);     // time stamp going backwards
    add_event(CMD_SPARE, 48'd170, '1);
    add_event(CMD_TX, 48'd200, '1);
    add_event(CMD_CCA, 48'd300, 32'd50);
    add_event(CMD_QUERY, 48'd4294967506, 32'd0);

    // Random events: time mostly creeps forward at the pace of the durations
    tick = 48'h1_0000_1000;
    for (int i = 0; i < 324; i++) begin
      r = $urandom_range(99);
      if (r < 16) cmd = CMD_TX;
      else if (r < 36) cmd = CMD_RX;
      else if (r < 46) cmd = CMD_SW;
      else if (r < 61) cmd = CMD_RX_OK;
      else if (r < 70) cmd = CMD_RX_ERR;
      else if (r < 88) cmd = CMD_CCA;
      else if (r < 97) cmd = CMD_QUERY;
      else cmd = CMD_SPARE;
      r = $urandom_range(99);
      if (r < 5) dur = '0;
      else if (r < 9) dur = $urandom;
      else if (r < 17) dur = $urandom_range(65535);
      else dur = $urandom_range(300, 1);
      r = $urandom_range(99);
      if (r < 4) tick = tick - $urandom_range(200);
      else if (r < 12) tick = tick + $urandom;
      else if (r < 70) tick = tick + $urandom_range(120);
      else tick = tick + $urandom_range(600);
      add_event(cmd, tick, dur, (i == 120) || (i == 300));
    end

    // Top of the time range last: saturated tx and switching ends stay for good
    add_event(CMD_CCA, TIME_TOP - 48'd10, '1, 1'b1);
    add_event(CMD_QUERY, TIME_TOP - 48'd9, 32'd0);
    add_event(CMD_SW, TIME_TOP - 48'd8, 32'd3);
    add_event(CMD_RX, TIME_TOP - 48'd3, '1);
    add_event(CMD_RX_OK, TIME_TOP - 48'd2, 32'd0);
    add_event(CMD_TX, TIME_TOP - 48'd1, 32'd50);
    add_event(CMD_QUERY, TIME_TOP, 32'd0);
    add_event(CMD_TX, TIME_TOP, 32'd9);
    add_event(CMD_SW, TIME_TOP, 32'd1);
    add_event(CMD_QUERY, 48'd12345, 32'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (events_to_send.size() != 0 || in_tvalid) @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d events (%0d refused as illegal) giving %0d results, %0d records",
             events_taken, illegal_total, results_seen, records_total);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("PASS phy_medium_state_tracker_core");
    end else begin
      $display("FAIL phy_medium_state_tracker_core");
    end
    $finish;
  end

endmodule
